[rtl/support_point_matcher_unit_assert.svh]
// ============================================================================
// Support point matcher assertion macros
// Shared concurrent assertion forms used by the port checker.
// ============================================================================
`ifndef SUPPORT_POINT_MATCHER_UNIT_ASSERT_SVH
`define SUPPORT_POINT_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication
`define SPMU_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spmu assertion failed");

// next-cycle implication
`define SPMU_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spmu assertion failed");

`endif

[rtl/spmu_pkg.sv]
// ============================================================================
// Support point matcher package
// Widths, register codes, reset values and shared structs.
// ============================================================================
package spmu_pkg;

    localparam int DESC_BYTES  = 16;
    localparam int SAD_BYTES   = (DESC_BYTES < 16) ? DESC_BYTES : 16;
    localparam int GROUP_BYTES = 4;
    localparam int SAD_GROUPS  = (SAD_BYTES + GROUP_BYTES - 1) / GROUP_BYTES;
    localparam int GROUP_W     = $clog2(GROUP_BYTES * 255 + 1);
    localparam int SAD_W       = $clog2(SAD_BYTES * 255 + 1);

    localparam int WORD_W      = 64;
    localparam int DISP_W      = 8;
    localparam int MATCH_W     = 9;
    localparam int COST_W      = 14;
    localparam int COORD_W     = 12;
    localparam int DIM_W       = 13;
    localparam int RATIO_W     = 9;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam int MID_DEPTH_DEF = 8;
    localparam int OUT_DEPTH_DEF = 4;

    localparam logic [COST_W-1:0]         COST_NONE = '1;
    localparam logic signed [MATCH_W-1:0] DISP_NONE = '1;

    localparam logic [CFG_INDEX_W-1:0] REG_RATIO    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DISP = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISP = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT   = 3'd4;

    localparam logic [RATIO_W-1:0] RATIO_RESET    = 9'd218;
    localparam logic [DISP_W-1:0]  MIN_DISP_RESET = 8'd0;
    localparam logic [DISP_W-1:0]  MAX_DISP_RESET = 8'd255;
    localparam logic [DIM_W-1:0]   WIDTH_RESET    = 13'd1280;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET   = 13'd720;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [DISP_W-1:0]  min_disp;
        logic [DISP_W-1:0]  max_disp;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } cfg_t;

    typedef struct packed {
        logic [SAD_W-1:0]  sad;
        logic [DISP_W-1:0] cand;
        logic              last_part;
        logic              last_cand;
        logic              in_range;
        logic              border;
    } part_t;

    typedef struct packed {
        logic signed [MATCH_W-1:0] match;
        logic [COST_W-1:0]         best;
        logic [COST_W-1:0]         second;
    } result_t;

endpackage

[rtl/support_point_matcher_unit.sv]
// ============================================================================
// Support point matcher unit
// Stereo support-point disparity search with SAD cost and ratio test.
// ============================================================================
// channel   handshake                accepted when
// input     push / full              push && !full
// result    empty / pop              pop && !empty
// config    cfg_valid / cfg_ready    cfg_valid && cfg_ready
//
// One descriptor part per cycle while full is low; the back end accumulates
// and compares costs as each part is taken. A part passes front stages s1,
// s2 and the middle queue to reach the back end; a result passes the emit
// register and result queue. full rises when the middle queue and front stages
// hold MID_DEPTH parts; the back end holds when the result queue is full.
// Reset clears all queues and the search state; config takes reset values.
module support_point_matcher_unit #(
    parameter int MID_DEPTH = spmu_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = spmu_pkg::OUT_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [spmu_pkg::WORD_W-1:0]          left_bytes_low,
    input  logic [spmu_pkg::WORD_W-1:0]          left_bytes_high,
    input  logic [spmu_pkg::WORD_W-1:0]          right_bytes_low,
    input  logic [spmu_pkg::WORD_W-1:0]          right_bytes_high,
    input  logic [spmu_pkg::DISP_W-1:0]          candidate,
    input  logic                                 last_part,
    input  logic                                 last_candidate,
    input  logic [spmu_pkg::COORD_W-1:0]         pixel_u,
    input  logic [spmu_pkg::COORD_W-1:0]         pixel_v,
    input  logic                                 right_reference,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [spmu_pkg::MATCH_W-1:0]  match,
    output logic [spmu_pkg::COST_W-1:0]          best_cost,
    output logic [spmu_pkg::COST_W-1:0]          second_cost,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spmu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [spmu_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import spmu_pkg::*;

    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    cfg_t                    cfg_reg;
    logic                    part_push;
    part_t                   part_in;
    part_t                   part_out;
    logic                    part_take;
    logic [MID_CNT_W-1:0]    mid_count;
    logic                    res_push;
    result_t                 res_in;
    result_t                 res_out;
    logic [OUT_CNT_W-1:0]    out_count;
    logic                    res_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ratio    <= RATIO_RESET;
            cfg_reg.min_disp <= MIN_DISP_RESET;
            cfg_reg.max_disp <= MAX_DISP_RESET;
            cfg_reg.width    <= WIDTH_RESET;
            cfg_reg.height   <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RATIO:    cfg_reg.ratio    <= cfg_data[RATIO_W-1:0];
                REG_MIN_DISP: cfg_reg.min_disp <= cfg_data[DISP_W-1:0];
                REG_MAX_DISP: cfg_reg.max_disp <= cfg_data[DISP_W-1:0];
                REG_WIDTH:    cfg_reg.width    <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:   cfg_reg.height   <= cfg_data[DIM_W-1:0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    spmu_front #(
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .push             (push),
        .full             (full),
        .left_bytes_low   (left_bytes_low),
        .left_bytes_high  (left_bytes_high),
        .right_bytes_low  (right_bytes_low),
        .right_bytes_high (right_bytes_high),
        .candidate        (candidate),
        .last_part        (last_part),
        .last_candidate   (last_candidate),
        .pixel_u          (pixel_u),
        .pixel_v          (pixel_v),
        .right_reference  (right_reference),
        .mid_count        (mid_count),
        .part_push        (part_push),
        .part_data        (part_in)
    );

    spmu_queue #(
        .DEPTH (MID_DEPTH),
        .WIDTH ($bits(part_t))
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (part_push),
        .wr_data (part_in),
        .rd_en   (part_take),
        .rd_data (part_out),
        .count   (mid_count)
    );

    spmu_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ratio      (cfg_reg.ratio),
        .part_valid (mid_count != '0),
        .part_data  (part_out),
        .part_take  (part_take),
        .out_count  (out_count),
        .res_push   (res_push),
        .res_data   (res_in)
    );

    assign empty   = (out_count == '0);
    assign res_pop = pop && !empty;

    spmu_queue #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(result_t))
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (res_pop),
        .rd_data (res_out),
        .count   (out_count)
    );

    assign match       = res_out.match;
    assign best_cost   = res_out.best;
    assign second_cost = res_out.second;

endmodule

[rtl/spmu_queue.sv]
// ============================================================================
// Support point matcher queue
// Small register queue with occupancy count; DEPTH must be a power of two, which the queue does not check.
// ============================================================================
module spmu_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

endmodule

[rtl/spmu_front.sv]
// ============================================================================
// Support point matcher front end
// Part SAD, disparity range check and border check in two stages.
// ============================================================================
module spmu_front #(
    parameter int MID_DEPTH = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  spmu_pkg::cfg_t                   cfg,
    input  logic                             push,
    output logic                             full,
    input  logic [spmu_pkg::WORD_W-1:0]      left_bytes_low,
    input  logic [spmu_pkg::WORD_W-1:0]      left_bytes_high,
    input  logic [spmu_pkg::WORD_W-1:0]      right_bytes_low,
    input  logic [spmu_pkg::WORD_W-1:0]      right_bytes_high,
    input  logic [spmu_pkg::DISP_W-1:0]      candidate,
    input  logic                             last_part,
    input  logic                             last_candidate,
    input  logic [spmu_pkg::COORD_W-1:0]     pixel_u,
    input  logic [spmu_pkg::COORD_W-1:0]     pixel_v,
    input  logic                             right_reference,
    input  logic [$clog2(MID_DEPTH+1)-1:0]   mid_count,
    output logic                             part_push,
    output spmu_pkg::part_t                  part_data
);

    import spmu_pkg::*;

    localparam int CNT_W  = $clog2(MID_DEPTH + 1);
    localparam int LIM_W  = DIM_W + 1;
    localparam int UP_W   = 2 * LIM_W;
    localparam int DN_W   = 2 * DIM_W;
    localparam int SUM_W  = UP_W + 1;

    logic [2*WORD_W-1:0]       left_word;
    logic [2*WORD_W-1:0]       right_word;
    logic [7:0]                byte_a;
    logic [7:0]                byte_b;
    logic [GROUP_W-1:0]        grp_sum [SAD_GROUPS];
    logic signed [LIM_W-1:0]   lim;
    logic                      range_ok;
    logic signed [LIM_W-1:0]   v_minus;
    logic signed [LIM_W-1:0]   w_signed;
    logic [DIM_W-1:0]          v_plus;
    logic [CNT_W:0]            inflight;
    logic                      accept;

    logic                      s1_v_reg;
    logic [GROUP_W-1:0]        s1_grp_reg [SAD_GROUPS];
    logic [DISP_W-1:0]         s1_cand_reg;
    logic                      s1_lpart_reg;
    logic                      s1_lcand_reg;
    logic                      s1_range_reg;
    logic [COORD_W-1:0]        s1_u_reg;
    logic signed [UP_W-1:0]    s1_up_prod_reg;
    logic [DN_W-1:0]           s1_dn_prod_reg;
    logic [DN_W-1:0]           s1_area_reg;

    logic [SAD_W-1:0]          sad_sum;
    logic signed [SUM_W-1:0]   up_sum;
    logic [DN_W:0]             dn_sum;

    logic                      s2_v_reg;
    part_t                     s2_part_reg;

    assign inflight = (CNT_W+1)'(mid_count) + (CNT_W+1)'(s1_v_reg) + (CNT_W+1)'(s2_v_reg);
    assign full     = inflight >= (CNT_W+1)'(MID_DEPTH);
    assign accept   = push && !full;

    assign left_word  = {left_bytes_high, left_bytes_low};
    assign right_word = {right_bytes_high, right_bytes_low};

    always_comb
    begin
        byte_a = '0;
        byte_b = '0;
        for (int g = 0; g < SAD_GROUPS; g++)
        begin
            grp_sum[g] = '0;
            for (int b = 0; b < GROUP_BYTES; b++)
            begin
                if (g * GROUP_BYTES + b < SAD_BYTES)
                begin
                    byte_a = left_word[(g * GROUP_BYTES + b) * 8 +: 8];
                    byte_b = right_word[(g * GROUP_BYTES + b) * 8 +: 8];
                    grp_sum[g] = grp_sum[g] + GROUP_W'((byte_a > byte_b) ?
                                 (byte_a - byte_b) : (byte_b - byte_a));
                end
            end
        end
    end

    assign lim = right_reference ?
                 ($signed({1'b0, cfg.width}) - $signed(LIM_W'(pixel_u))) :
                 $signed(LIM_W'(pixel_u));

    assign range_ok = (candidate >= cfg.min_disp) && (candidate <= cfg.max_disp) &&
                      ($signed(LIM_W'(candidate)) <= lim);

    assign v_minus  = $signed(LIM_W'(pixel_v)) - LIM_W'(2);
    assign w_signed = $signed({1'b0, cfg.width});
    assign v_plus   = DIM_W'(pixel_v) + DIM_W'(2);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_grp_reg     <= grp_sum;
            s1_cand_reg    <= candidate;
            s1_lpart_reg   <= last_part;
            s1_lcand_reg   <= last_candidate;
            s1_range_reg   <= range_ok;
            s1_u_reg       <= pixel_u;
            s1_up_prod_reg <= v_minus * w_signed;
            s1_dn_prod_reg <= v_plus * cfg.width;
            s1_area_reg    <= cfg.width * cfg.height;
        end
    end

    always_comb
    begin
        sad_sum = '0;
        for (int g = 0; g < SAD_GROUPS; g++)
        begin
            sad_sum = sad_sum + SAD_W'(s1_grp_reg[g]);
        end
    end

    assign up_sum = SUM_W'(s1_up_prod_reg) + SUM_W'($signed({1'b0, s1_u_reg})) - SUM_W'(2);
    assign dn_sum = (DN_W+1)'(s1_dn_prod_reg) + (DN_W+1)'(s1_u_reg) + (DN_W+1)'(2);

    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
        begin
            s2_part_reg.sad       <= sad_sum;
            s2_part_reg.cand      <= s1_cand_reg;
            s2_part_reg.last_part <= s1_lpart_reg;
            s2_part_reg.last_cand <= s1_lcand_reg;
            s2_part_reg.in_range  <= s1_range_reg;
            s2_part_reg.border    <= (up_sum < 0) || (dn_sum > (DN_W+1)'(s1_area_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
        end
    end

    assign part_push = s2_v_reg;
    assign part_data = s2_part_reg;

endmodule

[rtl/spmu_back.sv]
// ============================================================================
// Support point matcher back end
// Cost accumulation, best and runner-up tracking and ratio test.
// ============================================================================
module spmu_back #(
    parameter int OUT_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [spmu_pkg::RATIO_W-1:0]     ratio,
    input  logic                             part_valid,
    input  spmu_pkg::part_t                  part_data,
    output logic                             part_take,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
    output logic                             res_push,
    output spmu_pkg::result_t                res_data
);

    import spmu_pkg::*;

    localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam int PROD_W = RATIO_W + COST_W;

    logic                        room;
    logic [COST_W:0]             total;
    logic [COST_W-1:0]           cost;
    logic                        keep;
    logic                        cand_end;

    logic [COST_W-1:0]           run_sum_reg;
    logic [COST_W-1:0]           low_cost_reg;
    logic signed [MATCH_W-1:0]   low_disp_reg;
    logic [COST_W-1:0]           sec_cost_reg;
    logic signed [MATCH_W-1:0]   sec_disp_reg;

    logic [COST_W-1:0]           low_cost_next;
    logic signed [MATCH_W-1:0]   low_disp_next;
    logic [COST_W-1:0]           sec_cost_next;
    logic signed [MATCH_W-1:0]   sec_disp_next;

    logic                        emit_v_reg;
    logic [COST_W-1:0]           emit_low_cost_reg;
    logic signed [MATCH_W-1:0]   emit_low_disp_reg;
    logic [COST_W-1:0]           emit_sec_cost_reg;
    logic signed [MATCH_W-1:0]   emit_sec_disp_reg;
    logic                        emit_border_reg;

    logic [PROD_W-1:0]           ratio_prod;
    logic [PROD_W-1:0]           low_scaled;
    logic                        unique_ok;

    assign room      = ((CNT_W+1)'(out_count) + (CNT_W+1)'(emit_v_reg)) <
                       (CNT_W+1)'(OUT_DEPTH);
    assign part_take = part_valid && room;

    assign total    = (COST_W+1)'(run_sum_reg) + (COST_W+1)'(part_data.sad);
    assign cost     = total[COST_W] ? COST_NONE : total[COST_W-1:0];
    assign keep     = part_data.in_range && (cost != '0);
    assign cand_end = part_data.last_part || part_data.last_cand;

    always_comb
    begin
        low_cost_next = low_cost_reg;
        low_disp_next = low_disp_reg;
        sec_cost_next = sec_cost_reg;
        sec_disp_next = sec_disp_reg;
        if (keep && (cost < low_cost_reg))
        begin
            sec_cost_next = low_cost_reg;
            sec_disp_next = low_disp_reg;
            low_cost_next = cost;
            low_disp_next = $signed(MATCH_W'(part_data.cand));
        end
        else if (keep && (cost < sec_cost_reg))
        begin
            sec_cost_next = cost;
            sec_disp_next = $signed(MATCH_W'(part_data.cand));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_sum_reg  <= '0;
            low_cost_reg <= COST_NONE;
            low_disp_reg <= DISP_NONE;
            sec_cost_reg <= COST_NONE;
            sec_disp_reg <= DISP_NONE;
            emit_v_reg   <= 1'b0;
        end
        else
        begin
            emit_v_reg <= part_take && part_data.last_cand;
            if (part_take)
            begin
                if (!cand_end)
                begin
                    run_sum_reg <= cost;
                end
                else if (part_data.last_cand)
                begin
                    run_sum_reg  <= '0;
                    low_cost_reg <= COST_NONE;
                    low_disp_reg <= DISP_NONE;
                    sec_cost_reg <= COST_NONE;
                    sec_disp_reg <= DISP_NONE;
                end
                else
                begin
                    run_sum_reg  <= '0;
                    low_cost_reg <= low_cost_next;
                    low_disp_reg <= low_disp_next;
                    sec_cost_reg <= sec_cost_next;
                    sec_disp_reg <= sec_disp_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (part_take && part_data.last_cand)
        begin
            emit_low_cost_reg <= low_cost_next;
            emit_low_disp_reg <= low_disp_next;
            emit_sec_cost_reg <= sec_cost_next;
            emit_sec_disp_reg <= sec_disp_next;
            emit_border_reg   <= part_data.border;
        end
    end

    assign ratio_prod = ratio * emit_sec_cost_reg;
    assign low_scaled = PROD_W'({emit_low_cost_reg, 8'b0});
    assign unique_ok  = !emit_border_reg && !emit_low_disp_reg[MATCH_W-1] &&
                        !emit_sec_disp_reg[MATCH_W-1] && (low_scaled < ratio_prod);

    assign res_push        = emit_v_reg;
    assign res_data.match  = unique_ok ? emit_low_disp_reg : DISP_NONE;
    assign res_data.best   = emit_low_cost_reg;
    assign res_data.second = emit_sec_cost_reg;

endmodule

[rtl/spmu_checker.sv]
// ============================================================================
// Support point matcher port checker
// Checks result consistency seen at the top-level ports.
// ============================================================================
`include "support_point_matcher_unit_assert.svh"

module spmu_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 empty,
    input  logic                                 pop,
    input  logic signed [spmu_pkg::MATCH_W-1:0]  match,
    input  logic [spmu_pkg::COST_W-1:0]          best_cost,
    input  logic [spmu_pkg::COST_W-1:0]          second_cost
);

    import spmu_pkg::*;

    logic match_seen;
    logic costs_known;
    logic waiting;

    assign match_seen  = !empty && (match != DISP_NONE);
    assign costs_known = (best_cost != COST_NONE) && (second_cost != COST_NONE) &&
                         (best_cost != '0);
    assign waiting     = !empty && !pop;

    `SPMU_ASSERT_IMP(a_cost_order, clk, rst_n, !empty, best_cost <= second_cost)
    `SPMU_ASSERT_IMP(a_match_costs, clk, rst_n, match_seen, costs_known)
    `SPMU_ASSERT_IMP(a_match_sign, clk, rst_n, !empty && match[MATCH_W-1], match == DISP_NONE)
    `SPMU_ASSERT_NXT(a_hold, clk, rst_n, waiting, !empty && $stable(match) && $stable(best_cost))

endmodule

bind support_point_matcher_unit spmu_checker u_spmu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .match       (match),
    .best_cost   (best_cost),
    .second_cost (second_cost)
);

[test/support_point_matcher_unit_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// Support point matcher unit testbench
// Streams descriptor parts for many pixels through the matcher under a range
// of register settings, with random gaps on the request side and random
// stalls on the result side. A built-in model tracks the SAD search and the
// ratio test and checks every match, best cost and second cost in order.
// ============================================================================
module support_point_matcher_unit_tb;
    import spmu_pkg::*;

    localparam int                     LIMIT      = 400000;
    localparam int                     PHASE_SIZE = 232;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [WORD_W-1:0]  ll;
        logic [WORD_W-1:0]  lh;
        logic [WORD_W-1:0]  rl;
        logic [WORD_W-1:0]  rh;
        logic [DISP_W-1:0]  cand;
        logic               lp;
        logic               lc;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        logic               rr;
    } part_req_t;

    class disparity_board;
        int unsigned ratio, min_d, max_d, width, height;
        int unsigned sum, low_cost, run_cost;
        int          low_disp, run_disp;
        result_t     owed[$];
        int          failures;
        int          checked;

        function new();
            ratio    = RATIO_RESET;
            min_d    = MIN_DISP_RESET;
            max_d    = MAX_DISP_RESET;
            width    = WIDTH_RESET;
            height   = HEIGHT_RESET;
            failures = 0;
            checked  = 0;
            clear_search();
        endfunction

        function void clear_search();
            sum      = 0;
            low_cost = COST_NONE;
            run_cost = COST_NONE;
            low_disp = -1;
            run_disp = -1;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RATIO:    ratio  = data[RATIO_W-1:0];
                REG_MIN_DISP: min_d  = data[DISP_W-1:0];
                REG_MAX_DISP: max_d  = data[DISP_W-1:0];
                REG_WIDTH:    width  = data[DIM_W-1:0];
                REG_HEIGHT:   height = data[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function void absorb_part(part_req_t p);
            logic [127:0] lv, rv;
            int           a, b, lo, hi, lim;
            longint       up, dn;
            bit           border;
            result_t      r;
            lv = {p.lh, p.ll};
            rv = {p.rh, p.rl};
            for (int i = 0; i < 16; i++)
            begin
                a = lv[8*i +: 8];
                b = rv[8*i +: 8];
                sum += (a > b) ? (a - b) : (b - a);
            end
            if (sum > COST_NONE)
                sum = COST_NONE;
            if (p.lp || p.lc)
            begin
                lo  = min_d;
                lim = p.rr ? (int'(width) - int'(p.u)) : int'(p.u);
                hi  = (int'(max_d) < lim) ? int'(max_d) : lim;
                if (int'(p.cand) >= lo && int'(p.cand) <= hi && sum != 0)
                begin
                    if (sum < low_cost)
                    begin
                        run_cost = low_cost;
                        run_disp = low_disp;
                        low_cost = sum;
                        low_disp = p.cand;
                    end
                    else if (sum < run_cost)
                    begin
                        run_cost = sum;
                        run_disp = p.cand;
                    end
                end
                sum = 0;
            end
            if (!p.lc)
                return;
            up = (longint'(p.v) - 2) * width + p.u - 2;
            dn = (longint'(p.v) + 2) * width + p.u + 2;
            border = (dn > longint'(width) * height) || (up < 0);
            r.match = DISP_NONE;
            if (!border && low_disp >= 0 && run_disp >= 0 &&
                longint'(low_cost) * 256 < longint'(ratio) * run_cost)
                r.match = low_disp[MATCH_W-1:0];
            r.best   = low_cost[COST_W-1:0];
            r.second = run_cost[COST_W-1:0];
            owed = {owed, r};
            clear_search();
        endfunction

        function void compare_result(logic signed [MATCH_W-1:0] m, logic [COST_W-1:0] b,
                                     logic [COST_W-1:0] s);
            result_t e;
            checked++;
            if (owed.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: match %0d best %0d second %0d", m, b, s);
                return;
            end
            e = owed.pop_front();
            if (e.match !== m || e.best !== b || e.second !== s)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected match %0d best %0d second %0d, got %0d %0d %0d",
                             e.match, e.best, e.second, m, b, s);
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        push = 1'b0;
    logic                        full;
    logic [WORD_W-1:0]           left_bytes_low = '0;
    logic [WORD_W-1:0]           left_bytes_high = '0;
    logic [WORD_W-1:0]           right_bytes_low = '0;
    logic [WORD_W-1:0]           right_bytes_high = '0;
    logic [DISP_W-1:0]           candidate = '0;
    logic                        last_part = 1'b0;
    logic                        last_candidate = 1'b0;
    logic [COORD_W-1:0]          pixel_u = '0;
    logic [COORD_W-1:0]          pixel_v = '0;
    logic                        right_reference = 1'b0;
    logic                        empty;
    logic                        pop = 1'b0;
    logic signed [MATCH_W-1:0]   match;
    logic [COST_W-1:0]           best_cost;
    logic [COST_W-1:0]           second_cost;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    disparity_board board = new();
    bit             gaps_on = 1'b1;
    int             pop_hold = 0;
    int             cycles = 0;
    int             parts_sent = 0;
    int             settings_used = 1;

    support_point_matcher_unit dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("support_point_matcher_unit test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            board.compare_result(match, best_cost, second_cost);
        if (pop_hold > 0)
        begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 15) == 0)
        begin
            pop_hold <= $urandom_range(0, 13);
            pop      <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    function automatic part_req_t with_desc(part_req_t p, int spread);
        logic [127:0] lv, rv;
        int           a, b, d;
        for (int i = 0; i < 16; i++)
        begin
            if (spread >= 256)
            begin
                a = $urandom_range(0, 1) ? 255 : 0;
                b = 255 - a;
            end
            else
            begin
                a = $urandom_range(0, 255);
                d = $urandom_range(0, spread);
                if ($urandom_range(0, 1))
                    b = (a + d > 255) ? 255 : a + d;
                else
                    b = (a < d) ? 0 : a - d;
            end
            lv[8*i +: 8] = a[7:0];
            rv[8*i +: 8] = b[7:0];
        end
        p.ll = lv[63:0];
        p.lh = lv[127:64];
        p.rl = rv[63:0];
        p.rh = rv[127:64];
        return p;
    endfunction

    function automatic int pick_spread();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 0;
        if (r < 40)
            return $urandom_range(1, 8);
        if (r < 75)
            return $urandom_range(9, 60);
        if (r < 95)
            return 255;
        return 256;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(int unsigned dim);
        int r, top;
        r   = $urandom_range(0, 99);
        top = (dim > 4096) ? 4095 : ((dim == 0) ? 0 : int'(dim) - 1);
        if (r < 70)
            return COORD_W'($urandom_range(0, top));
        if (r < 80)
            return COORD_W'($urandom_range(0, 3));
        if (r < 88)
            return COORD_W'($urandom_range((top > 3) ? top - 3 : 0, top));
        return COORD_W'($urandom_range(0, 4095));
    endfunction

    task automatic push_part(part_req_t p);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        push             <= 1'b1;
        left_bytes_low   <= p.ll;
        left_bytes_high  <= p.lh;
        right_bytes_low  <= p.rl;
        right_bytes_high <= p.rh;
        candidate        <= p.cand;
        last_part        <= p.lp;
        last_candidate   <= p.lc;
        pixel_u          <= p.u;
        pixel_v          <= p.v;
        right_reference  <= p.rr;
        do
            @(posedge clk);
        while (full);
        board.absorb_part(p);
        parts_sent++;
    endtask

    task automatic send_candidate(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v, bit rr,
                                  logic [DISP_W-1:0] cand, int nparts, int spread,
                                  bit is_last, bit cut);
        part_req_t p;
        for (int k = 0; k < nparts; k++)
        begin
            p      = '0;
            p.u    = u;
            p.v    = v;
            p.rr   = rr;
            p.cand = cand;
            p.lc   = is_last && (k == nparts - 1);
            p.lp   = (k == nparts - 1) && !(is_last && cut);
            push_part(with_desc(p, spread));
        end
    endtask

    task automatic random_pixel(bit clean);
        part_req_t          p;
        logic [COORD_W-1:0] u, v;
        logic [DISP_W-1:0]  c;
        bit                 rr;
        int                 ncand, np;
        if (!clean && $urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
            begin
                p.ll   = {$urandom, $urandom};
                p.lh   = {$urandom, $urandom};
                p.rl   = {$urandom, $urandom};
                p.rh   = {$urandom, $urandom};
                p.cand = DISP_W'($urandom_range(0, 255));
                p.lp   = 1'($urandom_range(0, 1));
                p.lc   = ($urandom_range(0, 3) == 0);
                p.u    = COORD_W'($urandom_range(0, 4095));
                p.v    = COORD_W'($urandom_range(0, 4095));
                p.rr   = 1'($urandom_range(0, 1));
                push_part(p);
            end
            return;
        end
        u     = pick_coord(board.width);
        v     = pick_coord(board.height);
        rr    = 1'($urandom_range(0, 1));
        ncand = $urandom_range(1, 6);
        for (int k = 0; k < ncand; k++)
        begin
            if ($urandom_range(0, 9) < 6 && board.min_d <= board.max_d)
                c = DISP_W'($urandom_range(board.min_d, board.max_d));
            else
                c = DISP_W'($urandom_range(0, 255));
            np = ($urandom_range(0, 99) < 85) ? 4 : $urandom_range(1, 6);
            send_candidate(u, v, rr, c, np, pick_spread(), k == ncand - 1,
                           $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic run_phase(bit allow_gaps);
        int goal;
        goal    = parts_sent + PHASE_SIZE;
        gaps_on = allow_gaps;
        while (parts_sent < goal)
        begin
            if (allow_gaps && $urandom_range(0, 19) == 0)
                gaps_on = !gaps_on;
            random_pixel(1'b0);
        end
        random_pixel(1'b1);
        push <= 1'b0;
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, int unsigned data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(idx, data[CFG_DATA_W-1:0]);
    endtask

    task automatic apply_setting(int unsigned r, int unsigned mn, int unsigned mx,
                                 int unsigned w, int unsigned h, bit stray);
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
        cfg_write(REG_RATIO, r);
        cfg_write(REG_MIN_DISP, mn);
        cfg_write(REG_MAX_DISP, mx);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        if (stray)
            cfg_write(REG_UNUSED, $urandom_range(0, 8191));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        part_req_t p;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // close costs, then a far one; unique best expected
        send_candidate(12'd600, 12'd300, 1'b0, 8'd5, 4, 3, 1'b0, 1'b0);
        send_candidate(12'd600, 12'd300, 1'b0, 8'd9, 4, 40, 1'b1, 1'b0);
        // pixel ended by last_candidate alone, zero cost
        p      = with_desc('0, 0);
        p.u    = 12'd100;
        p.v    = 12'd100;
        p.lc   = 1'b1;
        push_part(p);
        // saturating cost, then the largest unsaturated one
        send_candidate(12'd300, 12'd2, 1'b1, 8'd20, 5, 256, 1'b0, 1'b0);
        send_candidate(12'd300, 12'd2, 1'b1, 8'd21, 4, 256, 1'b1, 1'b0);
        // border pixel at the far corner
        send_candidate(12'd4095, 12'd4095, 1'b1, 8'd255, 1, 10, 1'b1, 1'b0);
        // right reference near the edge: first candidate out of range
        send_candidate(12'd1275, 12'd40, 1'b1, 8'd200, 1, 5, 1'b0, 1'b0);
        send_candidate(12'd1275, 12'd40, 1'b1, 8'd3, 1, 9, 1'b0, 1'b0);
        send_candidate(12'd1275, 12'd40, 1'b1, 8'd0, 1, 20, 1'b1, 1'b0);
        push <= 1'b0;

        run_phase(1'b1);
        apply_setting(256, 0, 255, 4096, 4096, 1'b0);
        run_phase(1'b1);
        apply_setting(0, 255, 0, 1, 1, 1'b0);
        run_phase(1'b1);
        apply_setting(128, 10, 60, 64, 48, 1'b1);
        run_phase(1'b1);
        apply_setting($urandom_range(0, 256), $urandom_range(0, 40), $urandom_range(30, 255),
                      $urandom_range(64, 4096), $urandom_range(16, 4096), 1'b0);
        run_phase(1'b1);
        apply_setting(200, 0, 100, 640, 480, 1'b0);
        run_phase(1'b1);
        apply_setting(218, 0, 255, 1280, 720, 1'b0);
        run_phase(1'b0);

        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.owed.size() != 0)
        begin
            board.failures += board.owed.size();
            $display("%0d expected results never arrived", board.owed.size());
        end
        $display("Sent %0d descriptor parts and checked %0d pixel results", parts_sent,
                 board.checked);
        $display("Register settings exercised: %0d, including extreme ranges and ratios",
                 settings_used);
        if (board.failures == 0)
            $display("support_point_matcher_unit test passed");
        else
            $display("support_point_matcher_unit test failed");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/spmu_pkg.sv
rtl/spmu_queue.sv
rtl/spmu_front.sv
rtl/spmu_back.sv
rtl/support_point_matcher_unit.sv
rtl/spmu_checker.sv
test/support_point_matcher_unit_tb.sv
